/* sv/led_blink_code_octet_signaler_core_defines.svh */
// assertion macros for the led blink code octet signaler
// no dependencies; included by the checker file only
`ifndef LED_BLINK_CODE_OCTET_SIGNALER_CORE_DEFINES_SVH
`define LED_BLINK_CODE_OCTET_SIGNALER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define LBCOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbcos: same-cycle property violated");

// next-cycle implication, held off during reset
`define LBCOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbcos: next-cycle property violated");

`endif

/* sv/lbcos_pkg.sv */
// shared types and timing constants of the led blink code octet signaler
// no dependencies; imported by the front, back and top level modules
package lbcos_pkg;

    // timing of the blink code: unit length in ticks, phase lengths in units, flash counts
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd100;
    localparam logic [3:0]  DIG_UNITS        = 4'd5;
    localparam logic [3:0]  FLASH_UNITS      = 4'd1;
    localparam logic [3:0]  SEP_GAP_UNITS    = 4'd7;
    localparam logic [3:0]  SEP_TAIL_UNITS   = 4'd9;
    localparam logic [3:0]  DONE_GAP_UNITS   = 4'd10;
    localparam logic [4:0]  SEP_FLASHES      = 5'd3;
    localparam logic [4:0]  DONE_FLASHES     = 5'd20;

    // item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // classified command between front and back
    typedef struct packed {
        logic            is_start;
        logic            quick;
        logic [7:0]      first_octet;
        logic [3:0][7:0] octets;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic finished;
    } res_t;

endpackage

/* sv/led_blink_code_octet_signaler_core.sv */
// top level of the led blink code octet signaler
// depends on lbcos_pkg, lbcos_fifo, lbcos_front and lbcos_back
//
// channel   | handshake           | payload
// ----------+---------------------+--------------------------------------------
// input     | push / full         | func, octet_a..octet_d, quick_only
// result    | pop / empty         | led_on, busy_res, finished
// config    | cfg_we              | cfg_wdata (unit_ticks)
//
// one transaction per clock in steady state while the result queue has room: the
// sequencer handles one command per cycle, limited by its single next-state path
// through the digit search. an item's result becomes poppable once it has passed the
// command queue and then the sequencer into the result queue.
// reset clears all queues and returns the sequencer to idle with the led off.
// a full result queue stalls the sequencer; the command queue then fills and raises full.
module led_blink_code_octet_signaler_core
    import lbcos_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [7:0]  octet_a,
    input  logic [7:0]  octet_b,
    input  logic [7:0]  octet_c,
    input  logic [7:0]  octet_d,
    input  logic        quick_only,
    output logic        empty,
    input  logic        pop,
    output logic        led_on,
    output logic        busy_res,
    output logic        finished,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic res_full;
    logic res_push;
    res_t res_in;
    res_t res_out;

    // accept and classify
    lbcos_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .octet_a    (octet_a),
        .octet_b    (octet_b),
        .octet_c    (octet_c),
        .octet_d    (octet_d),
        .quick_only (quick_only),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // blink sequencer
    lbcos_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue
    lbcos_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign led_on   = res_out.led_on;
    assign busy_res = res_out.busy_res;
    assign finished = res_out.finished;

endmodule

/* sv/lbcos_fifo.sv */
// small generic queue with registered entries, used for commands and results
// no dependencies
module lbcos_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/lbcos_front.sv */
// front part: accepts input items, classifies them and queues commands
// depends on lbcos_pkg and lbcos_fifo
module lbcos_front
    import lbcos_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       func,
    input  logic [7:0] octet_a,
    input  logic [7:0] octet_b,
    input  logic [7:0] octet_c,
    input  logic [7:0] octet_d,
    input  logic       quick_only,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    cmd_t cmd_in;
    logic cmd_empty;

    // classify the item and pick the first octet to be shown
    always_comb
    begin
        cmd_in.is_start    = (func == FUNC_START);
        cmd_in.quick       = quick_only;
        cmd_in.first_octet = quick_only ? octet_d : octet_a;
        cmd_in.octets      = {octet_d, octet_c, octet_b, octet_a};
    end

    lbcos_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

/* sv/lbcos_back.sv */
// back part: blink sequencer with unit prescaler, one command per cycle while
// the result queue has room; depends on lbcos_pkg
module lbcos_back
    import lbcos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic        res_full,
    output logic        res_push,
    output res_t        res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_DIG_ON   = 4'd1;
    localparam logic [3:0] PH_DIG_OFF  = 4'd2;
    localparam logic [3:0] PH_SEP_GAP  = 4'd3;
    localparam logic [3:0] PH_SEP_ON   = 4'd4;
    localparam logic [3:0] PH_SEP_OFF  = 4'd5;
    localparam logic [3:0] PH_SEP_TAIL = 4'd6;
    localparam logic [3:0] PH_DONE_GAP = 4'd7;
    localparam logic [3:0] PH_DONE_ON  = 4'd8;
    localparam logic [3:0] PH_DONE_OFF = 4'd9;

    localparam logic [1:0] PLACE_ONES_DONE = 2'd3;
    localparam logic [1:0] LAST_OCTET      = 2'd3;

    // state picked by the next-digit search
    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] units;
        logic       led;
        logic [4:0] flashes;
        logic [1:0] place;
        logic [7:0] rem;
    } adv_t;

    // first non-zero digit from the current place, else separator or final gap
    function automatic adv_t advance_f(input logic [7:0] r, input logic [1:0] p,
                                       input logic last, input logic [4:0] fl);
        adv_t       a;
        logic [1:0] h;
        logic [7:0] r1;
        logic [3:0] t;
        logic [7:0] o;
        h  = (r >= 8'd200) ? 2'd2 : ((r >= 8'd100) ? 2'd1 : 2'd0);
        r1 = r - ({6'd0, h} * 8'd100);
        t  = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (r1 >= 8'(k * 10))
            begin
                t = 4'(k);
            end
        end
        o = r1 - ({4'd0, t} * 8'd10);
        a.phase   = last ? PH_DONE_GAP : PH_SEP_GAP;
        a.units   = last ? DONE_GAP_UNITS : SEP_GAP_UNITS;
        a.led     = 1'b0;
        a.flashes = last ? fl : SEP_FLASHES;
        a.place   = PLACE_ONES_DONE;
        a.rem     = last ? 8'd0 : 8'd1;
        if (p != PLACE_ONES_DONE)
        begin
            if (h != 2'd0)
            begin
                a = '{PH_DIG_ON, DIG_UNITS, 1'b1, {3'd0, h}, 2'd1, r1};
            end
            else if (t != 4'd0)
            begin
                a = '{PH_DIG_ON, DIG_UNITS, 1'b1, {1'b0, t}, 2'd2, o};
            end
            else if (o != 8'd0)
            begin
                a = '{PH_DIG_ON, DIG_UNITS, 1'b1, o[4:0], PLACE_ONES_DONE, 8'd0};
            end
        end
        return a;
    endfunction

    logic [3:0]      phase_reg, phase_next;
    logic [3:0][7:0] store_reg, store_next;
    logic [1:0]      idx_reg, idx_next;
    logic [1:0]      place_reg, place_next;
    logic [7:0]      rem_reg, rem_next;
    logic [4:0]      flashes_reg, flashes_next;
    logic [3:0]      units_reg, units_next;
    logic [15:0]     pre_reg, pre_next;
    logic            led_reg, led_next;
    logic [15:0]     unit_ticks_reg;

    logic            take;
    logic            fin;
    logic            do_adv;
    logic [1:0]      idx_inc;
    logic [7:0]      adv_r;
    logic [1:0]      adv_p;
    logic            adv_last;
    adv_t            adv;
    logic [15:0]     limit;
    logic            unit_done;
    logic [3:0]      units_dec;
    logic [4:0]      flashes_dec;

    assign take     = cmd_valid && !res_full;
    assign cmd_pop  = take;
    assign res_push = take;

    // prescaler compare and counter decrements
    assign limit       = (unit_ticks_reg == 16'd0) ? 16'd1 : unit_ticks_reg;
    assign unit_done   = (({1'b0, pre_reg} + 17'd1) >= {1'b0, limit});
    assign units_dec   = units_reg - 4'd1;
    assign flashes_dec = flashes_reg - 5'd1;
    assign idx_inc     = idx_reg + 2'd1;

    // source of the digit search: new start, next octet, or current remainder
    always_comb
    begin
        if (cmd.is_start)
        begin
            adv_r    = cmd.first_octet;
            adv_p    = 2'd0;
            adv_last = cmd.quick;
        end
        else if (phase_reg == PH_SEP_TAIL && place_reg == PLACE_ONES_DONE)
        begin
            adv_r    = store_reg[idx_inc];
            adv_p    = 2'd0;
            adv_last = (idx_inc == LAST_OCTET);
        end
        else
        begin
            adv_r    = rem_reg;
            adv_p    = place_reg;
            adv_last = (idx_reg == LAST_OCTET);
        end
        adv = advance_f(adv_r, adv_p, adv_last, flashes_reg);
    end

    // sequencer next state
    always_comb
    begin
        phase_next   = phase_reg;
        store_next   = store_reg;
        idx_next     = idx_reg;
        place_next   = place_reg;
        rem_next     = rem_reg;
        flashes_next = flashes_reg;
        units_next   = units_reg;
        pre_next     = pre_reg;
        led_next     = led_reg;
        fin          = 1'b0;
        do_adv       = 1'b0;
        if (take)
        begin
            if (cmd.is_start)
            begin
                // start is ignored while a sequence runs
                if (phase_reg == PH_IDLE)
                begin
                    store_next = cmd.octets;
                    idx_next   = cmd.quick ? LAST_OCTET : 2'd0;
                    pre_next   = 16'd0;
                    do_adv     = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                pre_next = pre_reg + 16'd1;
                if (unit_done)
                begin
                    pre_next   = 16'd0;
                    units_next = units_dec;
                    if (units_dec == 4'd0)
                    begin
                        unique case (phase_reg)
                            PH_DIG_ON:
                            begin
                                phase_next = PH_DIG_OFF;
                                units_next = DIG_UNITS;
                                led_next   = 1'b0;
                            end
                            PH_DIG_OFF:
                            begin
                                flashes_next = flashes_dec;
                                if (flashes_dec != 5'd0)
                                begin
                                    phase_next = PH_DIG_ON;
                                    units_next = DIG_UNITS;
                                    led_next   = 1'b1;
                                end
                                else if (place_reg == 2'd1 || place_reg == 2'd2)
                                begin
                                    flashes_next = SEP_FLASHES;
                                    phase_next   = PH_SEP_GAP;
                                    units_next   = SEP_GAP_UNITS;
                                    led_next     = 1'b0;
                                end
                                else
                                begin
                                    do_adv = 1'b1;
                                end
                            end
                            PH_SEP_GAP:
                            begin
                                phase_next = PH_SEP_ON;
                                units_next = FLASH_UNITS;
                                led_next   = 1'b1;
                            end
                            PH_SEP_ON:
                            begin
                                phase_next = PH_SEP_OFF;
                                units_next = FLASH_UNITS;
                                led_next   = 1'b0;
                            end
                            PH_SEP_OFF:
                            begin
                                flashes_next = flashes_dec;
                                if (flashes_dec != 5'd0)
                                begin
                                    phase_next = PH_SEP_ON;
                                    units_next = FLASH_UNITS;
                                    led_next   = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_SEP_TAIL;
                                    units_next = SEP_TAIL_UNITS;
                                    led_next   = 1'b0;
                                end
                            end
                            PH_SEP_TAIL:
                            begin
                                if (place_reg != PLACE_ONES_DONE)
                                begin
                                    do_adv = 1'b1;
                                end
                                else if (rem_reg != 8'd0)
                                begin
                                    // second separator between octets
                                    rem_next     = 8'd0;
                                    flashes_next = SEP_FLASHES;
                                    phase_next   = PH_SEP_GAP;
                                    units_next   = SEP_GAP_UNITS;
                                    led_next     = 1'b0;
                                end
                                else
                                begin
                                    idx_next = idx_inc;
                                    do_adv   = 1'b1;
                                end
                            end
                            PH_DONE_GAP:
                            begin
                                flashes_next = DONE_FLASHES;
                                phase_next   = PH_DONE_ON;
                                units_next   = FLASH_UNITS;
                                led_next     = 1'b1;
                            end
                            PH_DONE_ON:
                            begin
                                phase_next = PH_DONE_OFF;
                                units_next = FLASH_UNITS;
                                led_next   = 1'b0;
                            end
                            PH_DONE_OFF:
                            begin
                                flashes_next = flashes_dec;
                                if (flashes_dec != 5'd0)
                                begin
                                    phase_next = PH_DONE_ON;
                                    units_next = FLASH_UNITS;
                                    led_next   = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    units_next = 4'd0;
                                    led_next   = 1'b0;
                                    fin        = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                units_next = 4'd0;
                                led_next   = 1'b0;
                            end
                        endcase
                    end
                end
            end
            // apply the digit search result
            if (do_adv)
            begin
                phase_next   = adv.phase;
                units_next   = adv.units;
                led_next     = adv.led;
                flashes_next = adv.flashes;
                place_next   = adv.place;
                rem_next     = adv.rem;
            end
        end
    end

    // result of this transaction
    always_comb
    begin
        res.led_on   = led_next;
        res.busy_res = (phase_next != PH_IDLE);
        res.finished = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            store_reg      <= '0;
            idx_reg        <= '0;
            place_reg      <= '0;
            rem_reg        <= '0;
            flashes_reg    <= '0;
            units_reg      <= '0;
            pre_reg        <= '0;
            led_reg        <= 1'b0;
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            store_reg   <= store_next;
            idx_reg     <= idx_next;
            place_reg   <= place_next;
            rem_reg     <= rem_next;
            flashes_reg <= flashes_next;
            units_reg   <= units_next;
            pre_reg     <= pre_next;
            led_reg     <= led_next;
            if (cfg_we)
            begin
                unit_ticks_reg <= cfg_wdata;
            end
        end
    end

endmodule

/* sv/lbcos_checker.sv */
// port-level checker for the led blink code octet signaler, with its bind
// depends on led_blink_code_octet_signaler_core_defines.svh
`include "led_blink_code_octet_signaler_core_defines.svh"

module lbcos_checker (
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input logic led_on,
    input logic busy_res,
    input logic finished
);

    // the end of the final flashes leaves the block idle and dark
    `LBCOS_ASSERT_SAME(a_fin_idle, clk, rst_n, !empty && finished, !busy_res && !led_on)

    // no light while no sequence runs
    `LBCOS_ASSERT_SAME(a_idle_dark, clk, rst_n, !empty && !busy_res, !led_on)

    // an unpopped result stays in place
    `LBCOS_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(led_on) && $stable(busy_res) && $stable(finished))

endmodule

bind led_blink_code_octet_signaler_core lbcos_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .led_on   (led_on),
    .busy_res (busy_res),
    .finished (finished)
);
